### design/csfw_pkg.sv
// Package: shared types, codes and defaults for the counting semaphore block.
package csfw_pkg;

  localparam int THREAD_W = 8;
  localparam int COUNT_W  = 16;
  localparam int WCOUNT_W = 5;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_THREAD_BITS = 8;
  localparam int DEF_COUNT_BITS  = 16;

  localparam logic [1:0] REQ_WAIT    = 2'd0;
  localparam logic [1:0] REQ_SIGNAL  = 2'd1;
  localparam logic [1:0] REQ_TIMEOUT = 2'd2;

  localparam logic [2:0] STS_ACQUIRED    = 3'd0;
  localparam logic [2:0] STS_QUEUED      = 3'd1;
  localparam logic [2:0] STS_WOULD_BLOCK = 3'd2;
  localparam logic [2:0] STS_WOKE        = 3'd3;
  localparam logic [2:0] STS_COUNTED     = 3'd4;
  localparam logic [2:0] STS_TIMED_OUT   = 3'd5;
  localparam logic [2:0] STS_IGNORED     = 3'd6;
  localparam logic [2:0] STS_REJECTED    = 3'd7;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [THREAD_W-1:0] thread_id;
    logic                blocking;
  } in_word_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [THREAD_W-1:0] thread_out;
    logic                thread_valid;
    logic [COUNT_W-1:0]  pending_count;
    logic [WCOUNT_W-1:0] waiter_count;
  } out_word_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

### design/csfw_ctrl.sv
// Controller: sequences capture and commit, owns the output valid flag.
module csfw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output csfw_pkg::cmd_t    cmd
);

  csfw_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      csfw_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = csfw_pkg::ST_EXEC;
      end
      csfw_pkg::ST_EXEC: begin
        if (slot_free) state_nxt = csfw_pkg::ST_IDLE;
      end
      default: state_nxt = csfw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      csfw_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      csfw_pkg::ST_EXEC: begin
        cmd.commit = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // result word waits in the output register while the next word is taken
  always_comb begin
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csfw_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/csfw_dp.sv
// Datapath: pending count, waiter queue cells, per-cell match and result register.
module csfw_dp #(
  parameter int QUEUE_DEPTH = csfw_pkg::DEF_QUEUE_DEPTH,
  parameter int THREAD_BITS = csfw_pkg::DEF_THREAD_BITS,
  parameter int COUNT_BITS  = csfw_pkg::DEF_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  csfw_pkg::cmd_t      cmd,
  input  csfw_pkg::in_word_t  in_word,
  output csfw_pkg::out_word_t out_word
);

  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW   = (THREAD_BITS > csfw_pkg::THREAD_W) ? THREAD_BITS : csfw_pkg::THREAD_W;
  localparam int CW   = (COUNT_BITS > csfw_pkg::COUNT_W) ? COUNT_BITS : csfw_pkg::COUNT_W;
  localparam int WW   = (CNTW > csfw_pkg::WCOUNT_W) ? CNTW : csfw_pkg::WCOUNT_W;

  logic [THREAD_BITS-1:0] cell_r [QUEUE_DEPTH];
  logic [CNTW-1:0]        total_r, total_nxt;
  logic [COUNT_BITS-1:0]  pend_r, pend_nxt;

  logic [1:0]             req_r;
  logic [THREAD_BITS-1:0] tid_r;
  logic                   blk_r;
  logic [QUEUE_DEPTH-1:0] match_r;

  logic [TW-1:0]          tid_wide;
  logic [THREAD_BITS-1:0] tid_in;
  logic [QUEUE_DEPTH-1:0] match_nxt;
  logic [QUEUE_DEPTH-1:0] prefix;

  logic                   found, full, empty, pend_zero, pend_max;
  logic                   push, pop, remove;
  logic [QUEUE_DEPTH-1:0] shift_sel;
  logic [2:0]             status;
  logic [THREAD_BITS-1:0] tout;
  logic                   tvalid;

  csfw_pkg::out_word_t    out_r;
  logic [TW-1:0]          tout_wide;
  logic [CW-1:0]          pend_wide;
  logic [WW-1:0]          total_wide;

  assign tid_wide = TW'(in_word.thread_id);
  assign tid_in   = tid_wide[THREAD_BITS-1:0];

  // compare the incoming thread against every occupied cell at capture
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      match_nxt[i] = (cell_r[i] == tid_in) && (total_r > CNTW'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r   <= in_word.req_type;
      tid_r   <= tid_in;
      blk_r   <= in_word.blocking;
      match_r <= match_nxt;
    end
  end

  // queued IDs are unique, so at most one match bit is set
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      prefix[i] = |(match_r & ({QUEUE_DEPTH{1'b1}} >> (QUEUE_DEPTH - 1 - i)));
    end
  end

  assign found     = |match_r;
  assign full      = (total_r == CNTW'(QUEUE_DEPTH));
  assign empty     = (total_r == '0);
  assign pend_zero = (pend_r == '0);
  assign pend_max  = &pend_r;

  always_comb begin
    status    = csfw_pkg::STS_REJECTED;
    tout      = '0;
    tvalid    = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    remove    = 1'b0;
    pend_nxt  = pend_r;
    total_nxt = total_r;
    case (req_r)
      csfw_pkg::REQ_WAIT: begin
        if (found) begin
          status = csfw_pkg::STS_REJECTED;
        end else if (!pend_zero) begin
          pend_nxt = pend_r - COUNT_BITS'(1);
          status   = csfw_pkg::STS_ACQUIRED;
        end else if (!blk_r) begin
          status = csfw_pkg::STS_WOULD_BLOCK;
        end else if (full) begin
          status = csfw_pkg::STS_REJECTED;
        end else begin
          push      = 1'b1;
          total_nxt = total_r + CNTW'(1);
          status    = csfw_pkg::STS_QUEUED;
        end
      end
      csfw_pkg::REQ_SIGNAL: begin
        if (!pend_zero || empty) begin
          if (!pend_max) pend_nxt = pend_r + COUNT_BITS'(1);
          status = csfw_pkg::STS_COUNTED;
        end else begin
          pop       = 1'b1;
          tout      = cell_r[0];
          tvalid    = 1'b1;
          total_nxt = total_r - CNTW'(1);
          status    = csfw_pkg::STS_WOKE;
        end
      end
      csfw_pkg::REQ_TIMEOUT: begin
        if (found) begin
          remove    = 1'b1;
          tout      = tid_r;
          tvalid    = 1'b1;
          total_nxt = total_r - CNTW'(1);
          status    = csfw_pkg::STS_TIMED_OUT;
        end else begin
          status = csfw_pkg::STS_IGNORED;
        end
      end
      default: begin
        status = csfw_pkg::STS_REJECTED;
      end
    endcase
  end

  // cells at and above the removed one take their upper neighbor
  assign shift_sel = pop ? {QUEUE_DEPTH{1'b1}} : (remove ? prefix : '0);

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    if (g < QUEUE_DEPTH - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (cmd.commit) begin
          if (push && (total_r == CNTW'(g))) cell_r[g] <= tid_r;
          else if (shift_sel[g]) cell_r[g] <= cell_r[g+1];
        end
      end
    end else begin : g_top
      always_ff @(posedge clk) begin
        if (cmd.commit && push && (total_r == CNTW'(g))) cell_r[g] <= tid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      total_r <= '0;
    end else if (cmd.commit) begin
      pend_r  <= pend_nxt;
      total_r <= total_nxt;
    end
  end

  assign tout_wide  = TW'(tout);
  assign pend_wide  = CW'(pend_nxt);
  assign total_wide = WW'(total_nxt);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.status        <= status;
      out_r.thread_out    <= tout_wide[csfw_pkg::THREAD_W-1:0];
      out_r.thread_valid  <= tvalid;
      out_r.pending_count <= pend_wide[csfw_pkg::COUNT_W-1:0];
      out_r.waiter_count  <= total_wide[csfw_pkg::WCOUNT_W-1:0];
    end
  end

  assign out_word = out_r;

endmodule

### design/counting_semaphore_fifo_waiters.sv
// Top level: counting semaphore with a FIFO queue of waiting threads.
// In the accept cycle of a request word its thread ID is compared against every queue
// cell in parallel, and in the update state that follows the decision is made, the
// pending count and the queue cells are updated and the result word is loaded into the
// output register. A new request is taken in the cycle after that, also while the
// previous result still waits; a result that is not taken by then holds the block in
// its update cycle until the output register frees up. The queue is a row of cells that
// shifts toward the head to close the gap left by a woken or timed-out thread, and needs
// no clearing pass after reset. Waits for a queued thread, blocking waits on a full
// queue and unknown request types return status rejected and change nothing.
module counting_semaphore_fifo_waiters #(
  parameter int QUEUE_DEPTH = csfw_pkg::DEF_QUEUE_DEPTH,
  parameter int THREAD_BITS = csfw_pkg::DEF_THREAD_BITS,
  parameter int COUNT_BITS  = csfw_pkg::DEF_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  csfw_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output csfw_pkg::out_word_t out_word
);

  csfw_pkg::cmd_t cmd;

  csfw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  csfw_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .THREAD_BITS (THREAD_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .out_word (out_word)
  );

endmodule
